// File: hw/rtl/asymmetric_ewma_per_bin_unit_macros.svh
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASYMMETRIC_EWMA_PER_BIN_UNIT_MACROS_SVH
`define ASYMMETRIC_EWMA_PER_BIN_UNIT_MACROS_SVH

`ifndef SYNTH

// checked only outside reset
`define AEWMA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("aewma assertion failed");

// checked on every edge, reset included
`define AEWMA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("aewma assertion failed");

`else

`define AEWMA_ASSERT(lbl, clk, rst_n, prop)
`define AEWMA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hw/rtl/aewma_pkg.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: package
// Field widths, register indexes and shared control types.
// ----------------------------------------------------------------------------
package aewma_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int FLEN_W    = 11;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = SAMPLE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_WT_RISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WT_FALL = 2'd1;

  localparam logic [CFG_W-1:0] ALPHA_RESET = 17'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // per-request frame control
  typedef struct packed {
    logic clear;
    logic last;
  } ctl_t;

  // pipeline status towards the input side
  typedef struct packed {
    logic space;
    logic hazard;
  } pipe_stat_t;

endpackage

// File: hw/rtl/aewma_in_if.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: input channel
// Valid/ready stream carrying one sample per request.
// ----------------------------------------------------------------------------
interface aewma_in_if;
  logic                            valid;
  logic                            ready;
  aewma_pkg::sample_t              sample;
  logic [aewma_pkg::FLEN_W-1:0]    frame_len;

  modport source (output valid, sample, frame_len, input ready);
  modport sink   (input valid, sample, frame_len, output ready);
endinterface

// File: hw/rtl/aewma_out_if.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: result channel
// Valid/ready stream carrying one average per request.
// ----------------------------------------------------------------------------
interface aewma_out_if;
  logic               valid;
  logic               ready;
  aewma_pkg::sample_t average;
  logic               frame_end;

  modport source (output valid, average, frame_end, input ready);
  modport sink   (input valid, average, frame_end, output ready);
endinterface

// File: hw/rtl/aewma_cfg_if.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: configuration channel
// Valid/ready register write port.
// ----------------------------------------------------------------------------
interface aewma_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aewma_pkg::CFG_IDX_W-1:0] index;
  logic [aewma_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/aewma_ram.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aewma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/aewma_seq.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: frame sequencer
// Tracks frame length, position and the clear flag of the current frame.
// ----------------------------------------------------------------------------
module aewma_seq #(
  parameter int FRAME_MAX = 1024,
  localparam int IDX_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1,
  localparam int LEN_W = $clog2(FRAME_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic [aewma_pkg::FLEN_W-1:0]   frame_len,
  output logic [IDX_W-1:0]               idx,
  output aewma_pkg::ctl_t                ctl,
  output logic                           fresh
);

  localparam int CMP_W = (LEN_W > aewma_pkg::FLEN_W) ? LEN_W : aewma_pkg::FLEN_W;

  logic             fresh_r;
  logic             clear_r;
  logic [LEN_W-1:0] len_r;
  logic [IDX_W-1:0] pos_r;

  logic [CMP_W-1:0] flen_ext;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] cur_len;
  logic [IDX_W-1:0] cur_pos;
  logic [LEN_W-1:0] pos_inc;
  logic             cur_clr;
  logic             cur_last;

  always_comb begin
    flen_ext = CMP_W'(frame_len);
    if (flen_ext == '0) begin
      len_sat = LEN_W'(1);
    end else if (flen_ext > CMP_W'(FRAME_MAX)) begin
      len_sat = LEN_W'(FRAME_MAX);
    end else begin
      len_sat = LEN_W'(flen_ext);
    end
  end

  assign cur_len  = fresh_r ? len_sat : len_r;
  assign cur_clr  = fresh_r ? (len_sat != len_r) : clear_r;
  assign cur_pos  = fresh_r ? '0 : pos_r;
  assign pos_inc  = LEN_W'(cur_pos) + LEN_W'(1);
  assign cur_last = (pos_inc >= cur_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
      clear_r <= 1'b0;
      len_r   <= '0;
      pos_r   <= '0;
    end else if (acc) begin
      fresh_r <= cur_last;
      clear_r <= cur_clr;
      len_r   <= cur_len;
      pos_r   <= cur_last ? '0 : IDX_W'(pos_inc);
    end
  end

  assign idx       = cur_pos;
  assign ctl.clear = cur_clr;
  assign ctl.last  = cur_last;
  assign fresh     = fresh_r;

endmodule

// File: hw/rtl/aewma_pipe.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: update pipeline
// Read, compare, multiply, add and write back around the bin state RAM.
// ----------------------------------------------------------------------------
module aewma_pipe #(
  parameter int FRAME_MAX       = 1024,
  parameter int ALPHA_FRAC_BITS = 16,
  localparam int IDX_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1,
  localparam int AW    = ALPHA_FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  aewma_pkg::sample_t   in_cur,
  input  logic [IDX_W-1:0]     in_idx,
  input  aewma_pkg::ctl_t      in_ctl,
  input  logic [AW-1:0]        wt_rise,
  input  logic [AW-1:0]        wt_fall,
  output aewma_pkg::pipe_stat_t stat,
  output logic                 o_vld,
  input  logic                 o_rdy,
  output aewma_pkg::sample_t   o_avg,
  output logic                 o_end
);

  localparam int SW = aewma_pkg::SAMPLE_W;
  localparam int DW = aewma_pkg::DIFF_W;
  localparam int PW = DW + AW + 1;

  // stage 1: RAM read in flight
  logic                 p1_vld_r;
  aewma_pkg::sample_t   p1_cur_r;
  aewma_pkg::ctl_t      p1_ctl_r;
  logic [IDX_W-1:0]     p1_idx_r;
  // stage 2: difference and weight
  logic                 p2_vld_r;
  aewma_pkg::sample_t   p2_cur_r;
  logic                 p2_last_r;
  logic [IDX_W-1:0]     p2_idx_r;
  logic signed [DW-1:0] p2_diff_r;
  logic [AW-1:0]        p2_alpha_r;
  // stage 3: product
  logic                 p3_vld_r;
  aewma_pkg::sample_t   p3_cur_r;
  logic                 p3_last_r;
  logic [IDX_W-1:0]     p3_idx_r;
  logic signed [PW-1:0] p3_prod_r;
  // result register
  logic                 o_vld_r;
  aewma_pkg::sample_t   o_avg_r;
  logic                 o_end_r;

  logic o_free, p3_free, p2_free, p1_free, wr_en;

  logic [2*SW-1:0]      rd_data;
  aewma_pkg::sample_t   old_avg, old_prev;
  logic signed [DW-1:0] p2_diff_nxt;
  logic [AW-1:0]        p2_alpha_nxt;
  logic signed [PW-1:0] p3_prod_nxt;
  logic signed [PW-1:0] prod_shr, sum;
  aewma_pkg::sample_t   o_avg_nxt;

  assign o_free  = !o_vld_r || o_rdy;
  assign p3_free = !p3_vld_r || o_free;
  assign p2_free = !p2_vld_r || p3_free;
  assign p1_free = !p1_vld_r || p2_free;
  assign wr_en   = p3_vld_r && o_free;

  aewma_ram #(
    .WIDTH (2 * SW),
    .DEPTH (FRAME_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p3_idx_r),
    .wdata ({o_avg_nxt, p3_cur_r}),
    .re    (in_vld),
    .raddr (in_idx),
    .rdata (rd_data)
  );

  // a bin still in flight has not been written back yet
  assign stat.hazard = (p1_vld_r && (p1_idx_r == in_idx)) ||
                       (p2_vld_r && (p2_idx_r == in_idx)) ||
                       (p3_vld_r && (p3_idx_r == in_idx));
  assign stat.space  = p1_free;

  always_comb begin
    old_avg      = p1_ctl_r.clear ? '0 : rd_data[2*SW-1:SW];
    old_prev     = p1_ctl_r.clear ? '0 : rd_data[SW-1:0];
    p2_diff_nxt  = {old_avg[SW-1], old_avg} - {p1_cur_r[SW-1], p1_cur_r};
    p2_alpha_nxt = (p1_cur_r > old_prev) ? wt_rise : wt_fall;
    p3_prod_nxt  = p2_diff_r * $signed({1'b0, p2_alpha_r});
    prod_shr     = p3_prod_r >>> ALPHA_FRAC_BITS;
    sum          = prod_shr + {{(PW-SW){p3_cur_r[SW-1]}}, p3_cur_r};
    o_avg_nxt    = sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_vld_r <= in_vld;
      end
      if (p2_free) begin
        p2_vld_r <= p1_vld_r;
      end
      if (p3_free) begin
        p3_vld_r <= p2_vld_r;
      end
      if (o_free) begin
        o_vld_r <= p3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_free && in_vld) begin
      p1_cur_r <= in_cur;
      p1_ctl_r <= in_ctl;
      p1_idx_r <= in_idx;
    end
    if (p2_free && p1_vld_r) begin
      p2_cur_r   <= p1_cur_r;
      p2_last_r  <= p1_ctl_r.last;
      p2_idx_r   <= p1_idx_r;
      p2_diff_r  <= p2_diff_nxt;
      p2_alpha_r <= p2_alpha_nxt;
    end
    if (p3_free && p2_vld_r) begin
      p3_cur_r  <= p2_cur_r;
      p3_last_r <= p2_last_r;
      p3_idx_r  <= p2_idx_r;
      p3_prod_r <= p3_prod_nxt;
    end
    if (wr_en) begin
      o_avg_r <= o_avg_nxt;
      o_end_r <= p3_last_r;
    end
  end

  assign o_vld = o_vld_r;
  assign o_avg = o_avg_r;
  assign o_end = o_end_r;

endmodule

// File: hw/rtl/asymmetric_ewma_per_bin_unit.sv
// ----------------------------------------------------------------------------
// Asymmetric EWMA per-bin unit: top level
// Per-bin moving average with separate rise and fall weights.
// ----------------------------------------------------------------------------
// channel    dir  handshake      payload
// in_chan    in   valid/ready    sample[23:0] s, frame_len[10:0]
// out_chan   out  valid/ready    average[23:0] s, frame_end
// cfg_chan   in   valid/ready    index[1:0], data[16:0]
//
// A request passes the RAM read, difference, product and result registers;
// one request per cycle is sustained while the output is not stalled and
// bins differ over four consecutive requests. Frames shorter than four
// bins stall: a bin is held off until its RAM read-modify-write is done.
// Synchronous reset; bin RAM is not cleared, a changed length zeroes a frame.
// Output stall backs up through a four-entry pipeline; input keeps flowing
// into free stages.
// ----------------------------------------------------------------------------
`include "asymmetric_ewma_per_bin_unit_macros.svh"

module asymmetric_ewma_per_bin_unit #(
  parameter int FRAME_MAX       = 1024,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  aewma_in_if.sink    in_chan,
  aewma_out_if.source out_chan,
  aewma_cfg_if.sink   cfg_chan
);

  localparam int IDX_W = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
  localparam int AW    = ALPHA_FRAC_BITS + 1;
  localparam int CW    = (AW > aewma_pkg::CFG_W) ? AW : aewma_pkg::CFG_W;

  logic [AW-1:0]         wt_rise_r, wt_fall_r;
  logic                  in_acc, cfg_wr, fresh;
  logic [IDX_W-1:0]      idx;
  aewma_pkg::ctl_t       ctl;
  aewma_pkg::pipe_stat_t stat;

  // weights above one saturate to one
  function automatic logic [AW-1:0] alpha_sat(input logic [aewma_pkg::CFG_W-1:0] v);
    logic [CW-1:0] ext;
    logic [CW-1:0] one;
    ext = CW'(v);
    one = CW'(1) << ALPHA_FRAC_BITS;
    return (ext > one) ? AW'(one) : AW'(ext);
  endfunction

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_rise_r <= alpha_sat(aewma_pkg::ALPHA_RESET);
      wt_fall_r <= alpha_sat(aewma_pkg::ALPHA_RESET);
    end else if (cfg_wr) begin
      if (cfg_chan.index == aewma_pkg::REG_WT_RISE) begin
        wt_rise_r <= alpha_sat(cfg_chan.data);
      end else if (cfg_chan.index == aewma_pkg::REG_WT_FALL) begin
        wt_fall_r <= alpha_sat(cfg_chan.data);
      end
    end
  end

  assign in_chan.ready = stat.space && !stat.hazard;
  assign in_acc        = in_chan.valid && in_chan.ready;

  aewma_seq #(
    .FRAME_MAX (FRAME_MAX)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .frame_len (in_chan.frame_len),
    .idx       (idx),
    .ctl       (ctl),
    .fresh     (fresh)
  );

  aewma_pipe #(
    .FRAME_MAX       (FRAME_MAX),
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_acc),
    .in_cur     (in_chan.sample),
    .in_idx     (idx),
    .in_ctl     (ctl),
    .wt_rise    (wt_rise_r),
    .wt_fall    (wt_fall_r),
    .stat       (stat),
    .o_vld      (out_chan.valid),
    .o_rdy      (out_chan.ready),
    .o_avg      (out_chan.average),
    .o_end      (out_chan.frame_end)
  );

  `AEWMA_ASSERT(a_frame_starts_at_zero, clk, rst_n, (in_acc && fresh) |-> (idx == '0))
  `AEWMA_ASSERT(a_last_opens_frame, clk, rst_n, (in_acc && ctl.last) |=> fresh)
  `AEWMA_ASSERT(a_mid_keeps_frame, clk, rst_n, (in_acc && !ctl.last) |=> !fresh)

endmodule
